// File: hw/rtl/mctt_pkg.sv
// Shared types and command codes for the multi-channel task timer.
`timescale 1ns / 1ps
`default_nettype none

package mctt_pkg;

  // Command codes on the request channel
  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_SET_DL = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  // Scan sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } scan_state_t;

  // Only the first sixteen channels can be addressed by a request
  localparam int IDX_W    = 4;
  localparam int TIME_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int ARG_W    = 32;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic                     create;
    logic                     set_dl;
    logic                     remove;
    logic                     clear;
    logic                     tick;
    logic                     advance;
    logic [TIME_W-1:0]        time_value;
    logic [TIME_W-1:0]        create_deadline;
    logic [TIME_W-1:0]        rearm_deadline;
    logic                     repeat_req;
    logic [HANDLE_W-1:0]      handler;
    logic signed [ARG_W-1:0]  argument;
    logic [TIME_W-1:0]        now;
  } cell_ctrl_t;

  // Per-cell expiry report, all zero unless the cell fires
  typedef struct packed {
    logic                     hit;
    logic [IDX_W-1:0]         index;
    logic [HANDLE_W-1:0]      handler;
    logic signed [ARG_W-1:0]  argument;
    logic [TIME_W-1:0]        period;
  } cell_out_t;

  // Unsigned add that sticks at all ones
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mctt_cell.sv
// One timer channel: its state, expiry flag and a stage of the scan token chain.
`timescale 1ns / 1ps
`default_nettype none

module mctt_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  mctt_pkg::cell_ctrl_t  ctrl,
  input  wire                   sel,
  input  wire                   tok_seed,
  input  wire                   tok_in,
  output logic                  tok_out,
  output mctt_pkg::cell_out_t   dout
);
  import mctt_pkg::*;

  localparam logic [IDX_W-1:0] IDX_BITS = IDX_W'(CELL_IDX % 16);

  // control state
  logic live_r, live_nxt;
  logic pend_r, pend_nxt;
  logic tok_r, tok_nxt;

  // channel payload, valid only while live
  logic [TIME_W-1:0]       period_r;
  logic [TIME_W-1:0]       deadline_r;
  logic                    reload_r;
  logic [HANDLE_W-1:0]     handler_r;
  logic signed [ARG_W-1:0] argument_r;

  logic fire;

  assign fire = tok_r && pend_r;

  // next control state
  always_comb begin
    live_nxt = live_r;
    pend_nxt = pend_r;
    tok_nxt  = tok_r;
    if (ctrl.clear) live_nxt = 1'b0;
    if (ctrl.remove && sel) live_nxt = 1'b0;
    if (ctrl.create && sel) live_nxt = 1'b1;
    // latch expiry for the whole scan at tick time
    if (ctrl.tick) begin
      pend_nxt = live_r && (ctrl.now >= deadline_r);
      tok_nxt  = tok_seed;
    end
    if (ctrl.advance) begin
      tok_nxt = tok_in;
      if (fire) begin
        pend_nxt = 1'b0;
        if (!reload_r) live_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      pend_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      live_r <= live_nxt;
      pend_r <= pend_nxt;
      tok_r  <= tok_nxt;
    end
  end

  // payload writes; create keeps the handler of a live channel
  always_ff @(posedge clk) begin
    if (ctrl.create && sel) begin
      if (!live_r) handler_r <= ctrl.handler;
      period_r   <= ctrl.time_value;
      deadline_r <= ctrl.create_deadline;
      reload_r   <= ctrl.repeat_req;
      argument_r <= ctrl.argument;
    end else if (ctrl.set_dl && sel && live_r) begin
      deadline_r <= ctrl.time_value;
    end else if (ctrl.advance && fire && reload_r) begin
      deadline_r <= ctrl.rearm_deadline;
    end
  end

  // gated report so the sequencer can OR all cells together
  always_comb begin
    dout          = '0;
    dout.hit      = fire;
    if (fire) begin
      dout.index    = IDX_BITS;
      dout.handler  = handler_r;
      dout.argument = argument_r;
      dout.period   = period_r;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: hw/rtl/multi_channel_task_timer_core.sv
// Top level: request decode, scan sequencer, result holding stage and the row of cells.
// Create, set deadline, remove and clear take effect in the cycle after acceptance.
// A tick occupies the block while the token walks the chain, one cell per cycle when the
// result side does not stall, and then through a flush.
// A result is held until the next firing cell or the flush.
// Reset: synchronous active-low; clears all live bits and sequencer state at once, no sweep.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_task_timer_core #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [2:0]                        in_cmd,
  input  wire  [mctt_pkg::IDX_W-1:0]        in_task_index,
  input  wire  [mctt_pkg::TIME_W-1:0]       in_time_value,
  input  wire                               in_repeat_req,
  input  wire  [mctt_pkg::HANDLE_W-1:0]     in_handler,
  input  wire  signed [mctt_pkg::ARG_W-1:0] in_argument,
  input  wire  [mctt_pkg::TIME_W-1:0]       in_now,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [mctt_pkg::IDX_W-1:0]        out_fired_index,
  output logic [mctt_pkg::HANDLE_W-1:0]     out_fired_handler,
  output logic signed [mctt_pkg::ARG_W-1:0] out_fired_argument,
  output logic                              out_last
);
  import mctt_pkg::*;

  scan_state_t state_r, state_nxt;

  logic [TIME_W-1:0]       now_r;
  logic                    hold_v_r, hold_v_nxt;
  cell_out_t               hold_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_index_r;
  logic [HANDLE_W-1:0]     out_handler_r;
  logic signed [ARG_W-1:0] out_argument_r;
  logic                    out_last_r;

  logic                    accept;
  logic                    out_free;
  logic                    advance;
  logic                    load_out;
  logic                    load_last;
  logic                    load_hold;
  logic                    hit;
  cell_out_t               sel_out;
  cell_ctrl_t              ctrl;

  logic [NUM_CHANNELS-1:0] sel;
  logic [NUM_CHANNELS-1:0] tok;
  logic [NUM_CHANNELS-1:0] hits;
  cell_out_t               cell_dout [NUM_CHANNELS];

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // channel address decode; channels beyond sixteen are never addressed
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_sel
    if (g < 16) begin : g_addr
      assign sel[g] = (in_task_index == IDX_W'(g));
    end else begin : g_none
      assign sel[g] = 1'b0;
    end
  end

  // merge the cell reports; at most one cell holds the token
  always_comb begin
    sel_out = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      sel_out = cell_out_t'(sel_out | cell_dout[i]);
      hits[i] = cell_dout[i].hit;
    end
  end
  assign hit = sel_out.hit;

  // request decode and broadcast
  always_comb begin
    ctrl                 = '0;
    ctrl.time_value      = in_time_value;
    ctrl.create_deadline = sat_add(in_now, in_time_value);
    ctrl.rearm_deadline  = sat_add(now_r, sel_out.period);
    ctrl.repeat_req      = in_repeat_req;
    ctrl.handler         = in_handler;
    ctrl.argument        = in_argument;
    ctrl.now             = in_now;
    ctrl.advance         = advance;
    if (accept) begin
      case (in_cmd)
        CMD_CREATE: ctrl.create = (in_handler != '0);
        CMD_SET_DL: ctrl.set_dl = 1'b1;
        CMD_REMOVE: ctrl.remove = 1'b1;
        CMD_TICK:   ctrl.tick   = 1'b1;
        CMD_CLEAR:  ctrl.clear  = 1'b1;
        default:    ;
      endcase
    end
  end

  // sequencer: walk the token, keep one found result in hand so the last one is known
  always_comb begin
    state_nxt = state_r;
    advance   = 1'b0;
    load_out  = 1'b0;
    load_last = 1'b0;
    load_hold = 1'b0;
    hold_v_nxt = hold_v_r;
    case (state_r)
      ST_IDLE: begin
        if (ctrl.tick) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        advance = !(hit && hold_v_r && !out_free);
        if (advance && hit) begin
          load_hold  = 1'b1;
          load_out   = hold_v_r;
          hold_v_nxt = 1'b1;
        end
        if (advance && tok[NUM_CHANNELS-1]) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          load_out   = 1'b1;
          load_last  = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.tick) now_r <= in_now;
    if (load_hold) hold_r <= sel_out;
    if (load_out) begin
      out_index_r    <= hold_r.index;
      out_handler_r  <= hold_r.handler;
      out_argument_r <= hold_r.argument;
      out_last_r     <= load_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fired_index    = out_index_r;
  assign out_fired_handler  = out_handler_r;
  assign out_fired_argument = out_argument_r;
  assign out_last           = out_last_r;

  // row of channel cells with the token handed down the chain
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
    logic tok_prev;
    if (g == 0) begin : g_head
      assign tok_prev = 1'b0;
    end else begin : g_link
      assign tok_prev = tok[g-1];
    end
    mctt_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .sel      (sel[g]),
      .tok_seed (g == 0),
      .tok_in   (tok_prev),
      .tok_out  (tok[g]),
      .dout     (cell_dout[g])
    );
  end

`ifndef SYNTHESIS
  // token is unique while scanning, absent otherwise
  a_tok_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> $onehot(tok))
    else $error("scan token not one-hot");
  a_tok_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> (tok == '0))
    else $error("scan token outside scan");
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hits))
    else $error("more than one cell firing");
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hold_v_r)
    else $error("result held while idle");
  a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.tick |=> (state_r == ST_SCAN))
    else $error("tick did not start a scan");
`endif

endmodule

`default_nettype wire
